// ===== rtl/sha1_pkg.sv =====
// Shared types, constants and helpers for the SHA-1 hash engine.
package sha1_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned LEN_W   = 64;
	localparam int unsigned NCHAIN  = 5;
	localparam int unsigned IDX_W   = 3;

	// round function groups
	localparam logic [1:0] PH_CH   = 2'd0;
	localparam logic [1:0] PH_PAR1 = 2'd1;
	localparam logic [1:0] PH_MAJ  = 2'd2;
	localparam logic [1:0] PH_PAR2 = 2'd3;

	localparam logic [WORD_W-1:0] K_RND [4] = '{
		32'h5a82_7999, 32'h6ed9_eba1, 32'h8f1b_bcdc, 32'hca62_c1d6
	};

	localparam logic [WORD_W-1:0] H_INIT [NCHAIN] = '{
		32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476, 32'hc3d2_e1f0
	};

	localparam logic [WORD_W-1:0] PAD_80_WORD = 32'h8000_0000;

	// source of a word shifted into the block buffer
	typedef enum logic [2:0] {
		SRC_INPUT,
		SRC_FINAL,
		SRC_PAD80,
		SRC_ZERO,
		SRC_LEN_HI,
		SRC_LEN_LO
	} push_src_t;

	typedef struct packed {
		logic             push;
		push_src_t        src;
		logic             len_add;
		logic             load_vars;
		logic             round_step;
		logic [1:0]       phase;
		logic             chain_add;
		logic             chain_init;
		logic [IDX_W-1:0] out_idx;
	} sha1_cmd_t;

	// clamp a byte count to a full word
	function automatic logic [2:0] sat_bytes(input logic [2:0] bv);
		sat_bytes = (bv > 3'd4) ? 3'd4 : bv;
	endfunction

	// keep the leading bytes of a partial last word and append the 0x80 marker
	function automatic logic [WORD_W-1:0] pad_final(input logic [WORD_W-1:0] w,
			input logic [2:0] bv);
		case (bv)
			3'd0:    pad_final = PAD_80_WORD;
			3'd1:    pad_final = {w[31:24], 24'h80_0000};
			3'd2:    pad_final = {w[31:16], 16'h8000};
			3'd3:    pad_final = {w[31:8], 8'h80};
			default: pad_final = w;
		endcase
	endfunction

endpackage

// ===== rtl/sha1_hash_engine.sv =====
// Top level of the SHA-1 hash engine.
//
// Input channel (in_valid / in_stall): one item is one big-endian message
// word; message_word bits 31..24 hold the first byte. Words before the last
// carry four bytes (bytes_valid is ignored on them); the item with final_word
// set carries 0 to 4 leading bytes, values above four count as four.
// Output channel (out_valid / out_stall): five items per message, H0 through
// H4, digest_last set on H4. No item comes out for a non-final word.
//
// Flow: the sixteenth word of a block holds the input off while the 80
// rounds run on one shared round unit and then the chaining add is done.
// After the last word the engine pushes its padding one word per cycle (up
// to 18 words, with a second block when the length does not fit), runs the
// rounds, then shows the digest words one per cycle from the chaining
// registers while the output is not stalled.
// The input stalls from the last word until H4 has been taken. A stall on
// the output holds the current digest word. After H4 is taken the chaining
// words go back to the initial values for the next message.
// Reset (arst_n low) loads the initial hash values, clears the bit length
// and returns to idle; no clearing pass is needed.
module sha1_hash_engine import sha1_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [WORD_W-1:0] message_word,
	input  logic [2:0]        bytes_valid,
	input  logic              final_word,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] digest_word,
	output logic              digest_last
);

	sha1_cmd_t cmd;

	// sequencer: decide what to push, when to round, when to emit
	sha1_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.bytes_valid (bytes_valid),
		.final_word  (final_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_last (digest_last),
		.cmd         (cmd)
	);

	// datapath: schedule window, round registers, chaining words, length
	sha1_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.message_word (message_word),
		.bytes_valid  (bytes_valid),
		.final_word   (final_word),
		.digest_word  (digest_word)
	);

endmodule

// ===== rtl/sha1_ctrl.sv =====
// Sequencer of the SHA-1 engine: intake, padding, rounds and digest output.
module sha1_ctrl import sha1_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic [2:0] bytes_valid,
	input  logic      final_word,
	output logic      out_valid,
	input  logic      out_stall,
	output logic      digest_last,
	output sha1_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_ADD   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NCHAIN - 1);

	logic [2:0]       state_q;
	logic [3:0]       fill_q;
	logic [6:0]       round_q;
	logic [IDX_W-1:0] idx_q;
	logic             padding_q;
	logic             need80_q;
	logic             hi_done_q;
	logic             last_q;

	logic in_acc;
	logic out_acc;
	logic full_push;
	logic [2:0] bv_sat;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign digest_last = out_valid && (idx_q == LAST_IDX);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;
	assign bv_sat    = sat_bytes(bytes_valid);
	assign full_push = cmd.push && (fill_q == 4'd15);

	always_comb begin
		cmd            = '0;
		cmd.src        = SRC_ZERO;
		cmd.out_idx    = idx_q;
		if (round_q < 7'd20) begin
			cmd.phase = PH_CH;
		end else if (round_q < 7'd40) begin
			cmd.phase = PH_PAR1;
		end else if (round_q < 7'd60) begin
			cmd.phase = PH_MAJ;
		end else begin
			cmd.phase = PH_PAR2;
		end
		unique case (state_q)
			ST_IDLE: begin
				cmd.push    = in_acc;
				cmd.len_add = in_acc;
				cmd.src     = (final_word && bv_sat != 3'd4) ? SRC_FINAL : SRC_INPUT;
			end
			ST_PAD: begin
				cmd.push = 1'b1;
				if (need80_q) begin
					cmd.src = SRC_PAD80;
				end else if (fill_q == 4'd14) begin
					cmd.src = SRC_LEN_HI;
				end else if (hi_done_q) begin
					cmd.src = SRC_LEN_LO;
				end else begin
					cmd.src = SRC_ZERO;
				end
			end
			ST_ROUND: cmd.round_step = 1'b1;
			ST_ADD:   cmd.chain_add  = 1'b1;
			ST_OUT:   cmd.chain_init = out_acc && (idx_q == LAST_IDX);
			default: ;
		endcase
		cmd.load_vars = cmd.push && (fill_q == 4'd15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			round_q   <= '0;
			idx_q     <= '0;
			padding_q <= 1'b0;
			need80_q  <= 1'b0;
			hi_done_q <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			if (cmd.push) begin
				fill_q <= fill_q + 4'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (final_word) begin
							padding_q <= 1'b1;
							need80_q  <= (bv_sat == 3'd4);
							hi_done_q <= 1'b0;
						end
						if (full_push) begin
							state_q <= ST_ROUND;
							round_q <= '0;
						end else if (final_word) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (cmd.src == SRC_PAD80) begin
						need80_q <= 1'b0;
					end
					if (cmd.src == SRC_LEN_HI) begin
						hi_done_q <= 1'b1;
					end
					if (cmd.src == SRC_LEN_LO) begin
						last_q <= 1'b1;
					end
					if (full_push) begin
						state_q <= ST_ROUND;
						round_q <= '0;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 7'd1;
					if (round_q == LAST_ROUND) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (last_q) begin
						state_q <= ST_OUT;
						idx_q   <= '0;
					end else if (padding_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						if (idx_q == LAST_IDX) begin
							state_q   <= ST_IDLE;
							padding_q <= 1'b0;
							hi_done_q <= 1'b0;
							last_q    <= 1'b0;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/sha1_dp.sv =====
// Datapath of the SHA-1 engine: message schedule window, round unit, chaining words.
module sha1_dp import sha1_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  sha1_cmd_t         cmd,
	input  logic [WORD_W-1:0] message_word,
	input  logic [2:0]        bytes_valid,
	input  logic              final_word,
	output logic [WORD_W-1:0] digest_word
);

	logic [WORD_W-1:0] win_q   [16];
	logic [WORD_W-1:0] vars_q  [NCHAIN];
	logic [WORD_W-1:0] chain_q [NCHAIN];
	logic [LEN_W-1:0]  len_q;

	logic [WORD_W-1:0] push_word;
	logic [WORD_W-1:0] sched_x;
	logic [WORD_W-1:0] sched_word;
	logic [WORD_W-1:0] f_val;
	logic [WORD_W-1:0] t_val;
	logic [5:0]        len_inc;
	logic [2:0]        bv_sat;

	assign bv_sat = sat_bytes(bytes_valid);

	always_comb begin
		case (cmd.src)
			SRC_INPUT:  push_word = message_word;
			SRC_FINAL:  push_word = pad_final(message_word, bv_sat);
			SRC_PAD80:  push_word = PAD_80_WORD;
			SRC_LEN_HI: push_word = len_q[63:32];
			SRC_LEN_LO: push_word = len_q[31:0];
			default:    push_word = '0;
		endcase
	end

	// next schedule word, W[t+16] while the window holds W[t..t+15]
	assign sched_x    = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign sched_word = {sched_x[30:0], sched_x[31]};

	always_comb begin
		case (cmd.phase) inside
			PH_CH:           f_val = (vars_q[1] & vars_q[2]) | (~vars_q[1] & vars_q[3]);
			PH_MAJ:          f_val = (vars_q[1] & vars_q[2]) | (vars_q[1] & vars_q[3])
			                       | (vars_q[2] & vars_q[3]);
			PH_PAR1, PH_PAR2: f_val = vars_q[1] ^ vars_q[2] ^ vars_q[3];
			default:         f_val = '0;
		endcase
	end

	assign t_val = {vars_q[0][26:0], vars_q[0][31:27]} + f_val + vars_q[4]
	             + win_q[0] + K_RND[cmd.phase];

	assign len_inc = final_word ? {bv_sat, 3'b000} : 6'd32;

	// shift window: pushed words while filling, schedule words during rounds
	always_ff @(posedge clk) begin
		if (cmd.push || cmd.round_step) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= cmd.push ? push_word : sched_word;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_vars) begin
			for (int i = 0; i < NCHAIN; i++) begin
				vars_q[i] <= chain_q[i];
			end
		end else if (cmd.round_step) begin
			vars_q[0] <= t_val;
			vars_q[1] <= vars_q[0];
			vars_q[2] <= {vars_q[1][1:0], vars_q[1][31:2]};
			vars_q[3] <= vars_q[2];
			vars_q[4] <= vars_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCHAIN; i++) begin
				chain_q[i] <= H_INIT[i];
			end
			len_q <= '0;
		end else begin
			if (cmd.chain_init) begin
				for (int i = 0; i < NCHAIN; i++) begin
					chain_q[i] <= H_INIT[i];
				end
				len_q <= '0;
			end else begin
				if (cmd.chain_add) begin
					for (int i = 0; i < NCHAIN; i++) begin
						chain_q[i] <= chain_q[i] + vars_q[i];
					end
				end
				if (cmd.len_add) begin
					len_q <= len_q + LEN_W'(len_inc);
				end
			end
		end
	end

	always_comb begin
		case (cmd.out_idx)
			3'd0:    digest_word = chain_q[0];
			3'd1:    digest_word = chain_q[1];
			3'd2:    digest_word = chain_q[2];
			3'd3:    digest_word = chain_q[3];
			3'd4:    digest_word = chain_q[4];
			default: digest_word = chain_q[0];
		endcase
	end

endmodule

// ===== rtl/sha1_chk.sv =====
// Port-level checks for the SHA-1 hash engine, bound to the top level.
module sha1_chk import sha1_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              final_word,
	input logic              out_valid,
	input logic              out_stall,
	input logic [WORD_W-1:0] digest_word,
	input logic              digest_last
);

	// a stalled digest item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(digest_last))
		else $error("digest item changed under stall");

	// the engine goes busy after the last word of a message
	a_final_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && final_word |=> in_stall)
		else $error("input taken right after final word");

	// no input while a digest is being shown
	a_out_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open during digest output");

	// the digest stream ends with the last-marked word
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && digest_last |=> !out_valid)
		else $error("output continued after last digest word");

endmodule

bind sha1_hash_engine sha1_chk u_sha1_chk (.*);

// ===== tb/tb_sha1_hash_engine.sv =====
// Self-checking testbench for the SHA-1 hash engine: directed table, random messages, idling.
module tb_sha1_hash_engine;
	timeunit 1ns;
	timeprecision 1ps;
	import sha1_pkg::*;

	// Run-length knobs. QUIET_LIMIT must cover the long receiver hold-off plus two
	// padded blocks of rounds with the output stalled, with plenty of margin.
	localparam int RAND_ITEMS  = 350;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 200;
	localparam int QUIET_LIMIT = 3000;

	// H0 in element 0, H4 in element 4
	typedef logic [0:NCHAIN-1][WORD_W-1:0] digest_t;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic              last;
	} digest_item_t;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic [2:0]        nbytes;
		logic              fin;
		logic              known;  // digest typed in below instead of predicted
		digest_t           dig;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [WORD_W-1:0] message_word;
	logic [2:0]        bytes_valid;
	logic              final_word;
	logic              out_valid;
	logic              out_stall;
	logic [WORD_W-1:0] digest_word;
	logic              digest_last;

	// Sideband that travels with the offered item, driven like the payload so the
	// monitor sees the value that belongs to the item accepted at that edge.
	logic    tag_known;
	digest_t tag_digest;

	int idle_pct;
	int stall_pct;
	int hold_cnt;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	// Digest words still owed by the engine, oldest first.
	digest_item_t digest_q[$];
	stim_row_t    plan[$];

	// Predictor state: chaining words, partial block, message length in bits.
	digest_t           chain_h;
	logic [WORD_W-1:0] blk_w [16];
	logic [LEN_W-1:0]  msg_bits;
	int                fill_n;

	sha1_hash_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.message_word (message_word),
		.bytes_valid  (bytes_valid),
		.final_word   (final_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digest_word  (digest_word),
		.digest_last  (digest_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// Return the chaining words to the standard start and forget the message.
	task automatic restart_chain();
		for (int k = 0; k < NCHAIN; k++)
			chain_h[k] = H_INIT[k];
		msg_bits = '0;
		fill_n   = 0;
	endtask

	// Run the 80 rounds over the full block and fold the result into the chain.
	task automatic compress_block();
		logic [WORD_W-1:0] w [16];
		logic [WORD_W-1:0] a, b, c, d, e, f, t, wt;
		w = blk_w;
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 16) begin
				wt = w[r];
			end else begin
				wt = rotl32(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16], 1);
				w[r % 16] = wt;
			end
			// choose, parity, majority, parity
			if (r < 20)
				f = (b & c) | (~b & d);
			else if (r < 40 || r >= 60)
				f = b ^ c ^ d;
			else
				f = (b & c) | (b & d) | (c & d);
			t = rotl32(a, 5) + f + e + wt + K_RND[r / 20];
			e = d;
			d = c;
			c = rotl32(b, 30);
			b = a;
			a = t;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endtask

	task automatic absorb_word(input logic [WORD_W-1:0] wd);
		blk_w[fill_n] = wd;
		fill_n++;
		if (fill_n == 16) begin
			compress_block();
			fill_n = 0;
		end
	endtask

	// Advance the predictor by one accepted item; done is set when the item
	// closes a message and dg then holds its digest.
	task automatic predict_item(input logic [WORD_W-1:0] wd, input logic [2:0] nb,
			input logic fin, output logic done, output digest_t dg);
		int                n;
		logic [WORD_W-1:0] mask;
		done = 1'b0;
		dg   = '0;
		if (!fin) begin
			// byte count is ignored on all but the last word
			absorb_word(wd);
			msg_bits += 64'd32;
			return;
		end
		n = (nb > 3'd4) ? 4 : int'(nb);
		msg_bits += 64'(8 * n);
		if (n == 4) begin
			absorb_word(wd);
			absorb_word(PAD_80_WORD);
		end else begin
			// drop the unused trailing bytes, then place the marker right behind
			mask = (n == 0) ? '0 : (32'hffff_ffff << (32 - 8 * n));
			absorb_word((wd & mask) | (32'h80 << (24 - 8 * n)));
		end
		// zero fill up to the length field, spilling into a second block if needed
		while (fill_n != 14)
			absorb_word('0);
		absorb_word(msg_bits[63:32]);
		absorb_word(msg_bits[31:0]);
		dg = chain_h;
		restart_chain();
		done = 1'b1;
	endtask

	task automatic add_row(input logic [WORD_W-1:0] w, input logic [2:0] nb, input logic fin);
		stim_row_t row;
		row.word   = w;
		row.nbytes = nb;
		row.fin    = fin;
		row.known  = 1'b0;
		row.dig    = '0;
		plan.push_back(row);
	endtask

	// Offer one item, idling first at random, and hold it until the engine takes it.
	// Returns in the time step of the accepting edge.
	task automatic offer_item(input logic [WORD_W-1:0] w, input logic [2:0] nb,
			input logic fin, input logic known, input digest_t dg);
		while ($urandom_range(1, 100) <= idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		message_word <= w;
		bytes_valid  <= nb;
		final_word   <= fin;
		tag_known    <= known;
		tag_digest   <= dg;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// One message of random content: nwords full words, then a last word
	// carrying a random byte count (values above four included).
	task automatic send_message(input int nwords);
		for (int i = 0; i < nwords; i++)
			offer_item($urandom(), 3'($urandom_range(0, 7)), 1'b0, 1'b0, '0);
		offer_item($urandom(), 3'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
	endtask

	// Drop valid and hold until every owed digest word has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (digest_q.size() != 0);
	endtask

	// Receiver: a pending hold-off overrides the random stall.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cnt > 0) begin
				out_stall <= 1'b1;
				hold_cnt--;
			end else begin
				out_stall <= ($urandom_range(1, 100) <= stall_pct);
			end
		end
	end

	// Monitor: predict on every accepted input item, check every accepted digest word.
	always @(posedge clk) begin : monitor
		logic         got;
		digest_t      dg;
		digest_item_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_item(message_word, bytes_valid, final_word, got, dg);
				if (got) begin
					if (tag_known)
						dg = tag_digest;
					for (int k = 0; k < NCHAIN; k++)
						digest_q.push_back('{word: dg[k], last: (k == NCHAIN - 1)});
				end
			end
			if (out_valid && !out_stall) begin
				if (digest_q.size() == 0) begin
					$display("%0t: digest word %h last %b with none expected",
						$time, digest_word, digest_last);
					mismatch_count++;
				end else begin
					want = digest_q.pop_front();
					if (digest_word !== want.word) begin
						$display("%0t: digest_word expected %h actual %h",
							$time, want.word, digest_word);
						mismatch_count++;
					end
					if (digest_last !== want.last) begin
						$display("%0t: digest_last expected %b actual %b",
							$time, want.last, digest_last);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Watchdog: count cycles with no handshake on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		int nw;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		message_word <= '0;
		bytes_valid  <= '0;
		final_word   <= 1'b0;
		tag_known    <= 1'b0;
		tag_digest   <= '0;
		idle_pct  = 0;
		stall_pct = 0;
		hold_cnt  = 0;
		restart_chain();

		// Directed table. Empty message, with garbage in the unused word.
		add_row(32'hffff_ffff, 3'd0, 1'b1);
		plan[$].known = 1'b1;
		plan[$].dig   = {32'hda39_a3ee, 32'h5e6b_4b0d, 32'h3255_bfef, 32'h9560_1890, 32'hafd8_0709};
		// "abc"; the fourth byte must be forced to zero
		add_row(32'h6162_6364, 3'd3, 1'b1);
		plan[$].known = 1'b1;
		plan[$].dig   = {32'ha999_3e36, 32'h4706_816a, 32'hba3e_2571, 32'h7850_c26c, 32'h9cd0_d89d};
		// full word with an out-of-range count, then one byte
		add_row(32'h0000_0000, 3'd7, 1'b0);
		add_row(32'hffff_ffff, 3'd1, 1'b1);
		add_row(32'ha5a5_5a5a, 3'd2, 1'b1);
		// last-word counts above four saturate
		add_row(32'h8000_0001, 3'd5, 1'b1);
		add_row(32'h7fff_fffe, 3'd6, 1'b1);
		add_row(32'hffff_ffff, 3'd7, 1'b1);
		// 56 bytes: the length no longer fits, so padding needs a second block
		for (int i = 0; i < 13; i++)
			add_row(i[0] ? 32'hffff_ffff : 32'h0000_0000, 3'(i % 8), 1'b0);
		add_row(32'hdead_beef, 3'd4, 1'b1);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			offer_item(plan[i].word, plan[i].nbytes, plan[i].fin, plan[i].known, plan[i].dig);
		wait_drained();

		// Random messages in four idling phases; drain between phases.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 46; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 46; end
				default: begin idle_pct = 29; stall_pct = 29; end
			endcase
			// long receiver hold-off while the sender keeps offering
			if (ph == 0)
				hold_cnt = HOLD_CYCLES;
			sent = 0;
			while (sent < RAND_ITEMS / 4) begin
				// mostly short messages, now and then a multi-block one
				nw = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(0, 16);
				send_message(nw);
				sent += nw + 1;
			end
			wait_drained();
		end

		// catch any stray digest words before judging
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && digest_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
